// ===== rtl/core/lms_pkg.sv =====
package lms_pkg;
	localparam int MaxSamples = 64;
	localparam int RingAw = $clog2(MaxSamples);
	localparam int CountW = $clog2(MaxSamples + 1);
	localparam int SumW = 17 + CountW;
	localparam int RamW = 32 + 16 + 16 + 16;

	typedef enum logic [1:0] {
		PH_SETTLE = 2'd0,
		PH_STAND  = 2'd1,
		PH_WALK   = 2'd2,
		PH_BRAKE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_TOUCH  = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_SETTLE = 3'd1;
	localparam logic [2:0] REG_SPEED = 3'd2;
	localparam logic [2:0] REG_YAW = 3'd3;
	localparam logic [2:0] REG_WINDOW = 3'd4;
	localparam logic [2:0] REG_HOLD = 3'd5;
	localparam logic [2:0] REG_TIMEOUT = 3'd6;
	localparam logic [2:0] REG_TOUCH = 3'd7;

	localparam logic [1:0] MODE_WALK = 2'd0;
	localparam logic [1:0] MODE_INTER = 2'd2;
endpackage

// ===== rtl/core/locomotion_mode_supervisor_core.sv =====
// channel  | valid    | stall    | payload
// in       | in_valid | in_stall | command timestamp_ms vel_x vel_y yaw_rate
// out      | out_valid| out_stall| fsm_state mode ... toggle_accepted
// cfg      | cfg_we   | -        | cfg_index cfg_data
// Requests other than a braking tick before ready go from decode to output.
// A braking tick before ready also walks the ring-pop read/write states,
// once more per dropped ring entry, the window check and the compare; one
// ring RAM port pair and one shared compare/multiply path serialise it.
// One request in flight; in_stall is high until its result is taken.
// Reset leaves phase standing, sums and ring pointers cleared.
module locomotion_mode_supervisor_core import lms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [31:0]        timestamp_ms,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] yaw_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         fsm_state,
	output logic               mode,
	output logic               just_transitioned,
	output logic               reset_gait_clock,
	output logic               reset_swing_state,
	output logic               accept_velocity,
	output logic               zero_motion,
	output logic               swing_leg_dynamics,
	output logic               foot_jacobians,
	output logic               toggle_accepted
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_DEC   = 8'b00000010,
		S_POPRD = 8'b00000100,
		S_POPW  = 8'b00001000,
		S_CHKRD = 8'b00010000,
		S_CHKW  = 8'b00100000,
		S_CMP   = 8'b01000000,
		S_OUT   = 8'b10000000
	} st_t;

	st_t st_q;
	logic [1:0] rmode_q;
	logic [15:0] settle_q, win_q, hold_q, tmo_q;
	logic [14:0] spd_q, yawt_q;
	logic [7:0] tdth_q;

	phase_t phase_q;
	logic target_q, ready_q, moved_q, acc_q;
	logic [31:0] pst_q, rst_q, ast_q;
	logic [15:0] settled_q;
	logic [7:0] td_q;
	logic signed [SumW-1:0] sx_q, sy_q, sw_q;
	logic [RingAw-1:0] head_q;
	logic [CountW-1:0] cnt_q;
	logic [1:0] cmd_q;
	logic [31:0] t_q;
	logic signed [15:0] vx_q, vy_q, vw_q;
	logic [1:0] cmpi_q;
	logic cmpok_q;

	logic ram_we;
	logic [RingAw-1:0] ram_wa, ram_ra;
	logic [RamW-1:0] ram_wd, ram_rd;

	lms_ram #(.Width(RamW), .Depth(MaxSamples)) u_ring (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [31:0] rd_t;
	logic signed [15:0] rd_vx, rd_vy, rd_vw;
	assign {rd_t, rd_vx, rd_vy, rd_vw} = ram_rd;
	assign ram_wa = head_q + cnt_q[RingAw-1:0];
	assign ram_wd = {t_q, vx_q, vy_q, vw_q};
	assign ram_we = (st_q == S_POPW) && !(cnt_q == CountW'(MaxSamples));
	assign ram_ra = head_q;

	// shared compare: one sum against threshold * count per cycle
	logic signed [SumW-1:0] csum;
	logic [SumW-1:0] cmag;
	logic [14:0] cth;
	logic [SumW+14:0] cprod;
	always_comb begin
		case (cmpi_q)
			2'd0: begin csum = sx_q; cth = spd_q; end
			2'd1: begin csum = sy_q; cth = spd_q; end
			default: begin csum = sw_q; cth = yawt_q; end
		endcase
		cmag = csum[SumW-1] ? SumW'(-csum) : SumW'(csum);
		cprod = (SumW+15)'(cth) * (SumW+15)'(cnt_q);
	end

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	logic wm;
	assign wm = (phase_q == PH_WALK) || (phase_q == PH_BRAKE);
	assign fsm_state = phase_q;
	assign mode = wm;
	assign just_transitioned = moved_q;
	assign reset_gait_clock = moved_q && (phase_q != PH_BRAKE);
	assign reset_swing_state = reset_gait_clock;
	assign accept_velocity = (phase_q == PH_WALK);
	assign zero_motion = (phase_q == PH_BRAKE);
	assign swing_leg_dynamics = wm;
	assign foot_jacobians = !wm;
	assign toggle_accepted = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmode_q <= 2'd1;
			settle_q <= '0; spd_q <= '0; yawt_q <= '0; win_q <= '0;
			hold_q <= '0; tmo_q <= '0; tdth_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: rmode_q <= cfg_data[1:0];
				REG_SETTLE: settle_q <= cfg_data;
				REG_SPEED: spd_q <= cfg_data[14:0];
				REG_YAW: yawt_q <= cfg_data[14:0];
				REG_WINDOW: win_q <= cfg_data;
				REG_HOLD: hold_q <= cfg_data;
				REG_TIMEOUT: tmo_q <= cfg_data;
				REG_TOUCH: tdth_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			cmd_q <= command; t_q <= timestamp_ms;
			vx_q <= vel_x; vy_q <= vel_y; vw_q <= yaw_rate;
		end
	end

	phase_t nxt;
	logic go;
	always_comb begin
		go = 1'b0;
		nxt = phase_q;
		if (target_q) begin
			if (phase_q == PH_STAND || phase_q == PH_BRAKE) begin
				go = 1'b1; nxt = PH_WALK;
			end
		end else if (phase_q == PH_WALK) begin
			go = 1'b1; nxt = PH_BRAKE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			phase_q <= PH_STAND; target_q <= 1'b0; ready_q <= 1'b0;
			pst_q <= '0; rst_q <= '0; ast_q <= '0; settled_q <= '0; td_q <= '0;
			sx_q <= '0; sy_q <= '0; sw_q <= '0; head_q <= '0; cnt_q <= '0;
			moved_q <= 1'b0; acc_q <= 1'b0; cmpi_q <= '0; cmpok_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= S_DEC; moved_q <= 1'b0; acc_q <= 1'b0;
				end
				S_DEC: begin
					st_q <= S_OUT;
					case (cmd_q)
						CMD_START: begin
							target_q <= (rmode_q == MODE_WALK);
							pst_q <= t_q; rst_q <= '0; ast_q <= '0;
							ready_q <= 1'b0; settled_q <= '0; td_q <= '0;
							sx_q <= '0; sy_q <= '0; sw_q <= '0;
							head_q <= '0; cnt_q <= '0;
							if (settle_q != '0 &&
								(rmode_q == MODE_WALK || rmode_q == MODE_INTER))
								phase_q <= PH_SETTLE;
							else
								phase_q <= (rmode_q == MODE_WALK) ? PH_WALK : PH_STAND;
						end
						CMD_TOGGLE: begin
							if (rmode_q == MODE_INTER && phase_q != PH_SETTLE &&
								phase_q != PH_BRAKE && target_q == wm) begin
								target_q <= !target_q; acc_q <= 1'b1;
							end
						end
						CMD_TOUCH: begin
							if (phase_q == PH_BRAKE && ready_q && td_q != 8'hFF)
								td_q <= td_q + 8'd1;
						end
						default: begin
							if (phase_q == PH_SETTLE) begin
								if (t_q - pst_q >= {16'd0, settle_q}) begin
									phase_q <= target_q ? PH_WALK : PH_STAND;
									pst_q <= t_q; settled_q <= '0; ready_q <= 1'b0;
									td_q <= '0; sx_q <= '0; sy_q <= '0; sw_q <= '0;
									head_q <= '0; cnt_q <= '0; moved_q <= 1'b1;
								end
							end else if (go) begin
								phase_q <= nxt; pst_q <= t_q; settled_q <= '0;
								ready_q <= 1'b0; td_q <= '0; moved_q <= 1'b1;
								sx_q <= '0; sy_q <= '0; sw_q <= '0;
								head_q <= '0; cnt_q <= '0;
								if (nxt == PH_BRAKE) begin
									rst_q <= t_q; ast_q <= t_q;
								end
							end else if (phase_q == PH_BRAKE) begin
								if (!ready_q) begin
									st_q <= S_POPRD;
								end else if (td_q >= tdth_q ||
									t_q - rst_q >= {16'd0, tmo_q}) begin
									phase_q <= PH_STAND; pst_q <= t_q;
									settled_q <= '0; ready_q <= 1'b0; td_q <= '0;
									sx_q <= '0; sy_q <= '0; sw_q <= '0;
									head_q <= '0; cnt_q <= '0; moved_q <= 1'b1;
								end
							end
						end
					endcase
				end
				S_POPRD: st_q <= S_POPW;
				S_POPW: begin
					// drop oldest when full, then store the new sample
					if (cnt_q == CountW'(MaxSamples)) begin
						sx_q <= sx_q - SumW'(rd_vx); sy_q <= sy_q - SumW'(rd_vy);
						sw_q <= sw_q - SumW'(rd_vw);
						head_q <= head_q + 1'b1; cnt_q <= cnt_q - 1'b1;
						st_q <= S_POPRD;
					end else begin
						sx_q <= sx_q + SumW'(vx_q); sy_q <= sy_q + SumW'(vy_q);
						sw_q <= sw_q + SumW'(vw_q);
						cnt_q <= cnt_q + 1'b1;
						st_q <= S_CHKRD;
					end
				end
				S_CHKRD: st_q <= S_CHKW;
				S_CHKW: begin
					if (cnt_q > CountW'(1) && t_q - rd_t > {16'd0, win_q}) begin
						sx_q <= sx_q - SumW'(rd_vx); sy_q <= sy_q - SumW'(rd_vy);
						sw_q <= sw_q - SumW'(rd_vw);
						head_q <= head_q + 1'b1; cnt_q <= cnt_q - 1'b1;
						st_q <= S_CHKRD;
					end else begin
						cmpi_q <= '0;
						cmpok_q <= !(win_q != '0 && t_q - ast_q < {16'd0, win_q});
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cmpi_q == 2'd3) begin
						st_q <= S_OUT;
						if (cmpok_q) begin
							if (settled_q != 16'hFFFF) settled_q <= settled_q + 16'd1;
							if ((settled_q == 16'hFFFF ? settled_q : settled_q + 16'd1)
								>= hold_q) begin
								ready_q <= 1'b1; rst_q <= t_q; td_q <= '0;
							end
						end else begin
							settled_q <= '0;
						end
					end else begin
						if ((SumW+15)'(cmag) > cprod) cmpok_q <= 1'b0;
						cmpi_q <= cmpi_q + 2'd1;
					end
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("out without stall");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountW'(MaxSamples)) else $error("ring count overflow");
	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BRAKE && st_q == S_OUT) |-> cnt_q == '0)
		else $error("ring kept outside braking");
endmodule

// ===== rtl/core/lms_ram.sv =====
module lms_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== bench/tb_locomotion_mode_supervisor_core.sv =====
module tb_locomotion_mode_supervisor_core;
	import lms_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 300;

	typedef struct packed {
		logic [1:0] st;
		logic       md;
		logic       jt;
		logic       rgc;
		logic       rss;
		logic       av;
		logic       zm;
		logic       sld;
		logic       fj;
		logic       ta;
	} status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         command = '0;
	logic [31:0]        timestamp_ms = '0;
	logic signed [15:0] vel_x = '0;
	logic signed [15:0] vel_y = '0;
	logic signed [15:0] yaw_rate = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         fsm_state;
	logic               mode;
	logic               just_transitioned;
	logic               reset_gait_clock;
	logic               reset_swing_state;
	logic               accept_velocity;
	logic               zero_motion;
	logic               swing_leg_dynamics;
	logic               foot_jacobians;
	logic               toggle_accepted;

	locomotion_mode_supervisor_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// configuration copy
	localparam logic [1:0] MODE_STAND_RESET = 2'd1;
	logic [1:0]  c_mode = MODE_STAND_RESET;
	logic [15:0] c_settle = '0;
	logic [14:0] c_speed = '0;
	logic [14:0] c_yaw = '0;
	logic [15:0] c_win = '0;
	logic [15:0] c_hold = '0;
	logic [15:0] c_tmo = '0;
	logic [7:0]  c_touch = '0;

	// supervisor state copy
	phase_t                    ph = PH_STAND;
	logic                      tgt_walk = 1'b0;
	logic [31:0]               ph_t0 = '0;
	logic                      rdy = 1'b0;
	logic [31:0]               rdy_t0 = '0;
	logic [31:0]               avg_t0 = '0;
	logic [15:0]               settled = '0;
	logic [7:0]                touches = '0;
	logic [31:0]               ring_t [MaxSamples];
	logic signed [15:0]        ring_vx [MaxSamples];
	logic signed [15:0]        ring_vy [MaxSamples];
	logic signed [15:0]        ring_wz [MaxSamples];
	logic signed [SumW-1:0]    sum_vx = '0;
	logic signed [SumW-1:0]    sum_vy = '0;
	logic signed [SumW-1:0]    sum_wz = '0;
	logic [RingAw-1:0]         head = '0;
	logic [CountW-1:0]         fill = '0;

	status_t expected_status [$];
	int errors = 0;
	int burst_left = 0;
	logic [31:0] ts = '0;

	function automatic void drop_oldest();
		sum_vx -= ring_vx[head];
		sum_vy -= ring_vy[head];
		sum_wz -= ring_wz[head];
		head = head + 1'b1;
		fill = fill - 1'b1;
	endfunction

	function automatic void clear_ring();
		head = '0;
		fill = '0;
		sum_vx = '0;
		sum_vy = '0;
		sum_wz = '0;
	endfunction

	function automatic void enter_phase(phase_t nxt, logic [31:0] t);
		if (ph != nxt) begin
			ph = nxt;
			ph_t0 = t;
			settled = '0;
			rdy = 1'b0;
			touches = '0;
			if (nxt == PH_BRAKE) begin
				rdy_t0 = t;
				avg_t0 = t;
			end
			clear_ring();
		end
	endfunction

	function automatic status_t supervise(cmd_t cmd, logic [31:0] t, logic signed [15:0] vx,
			logic signed [15:0] vy, logic signed [15:0] wz);
		status_t r;
		logic moved;
		logic accepted;
		logic calm;
		logic walk_mode;
		logic [RingAw-1:0] slot;
		longint n;
		moved = 1'b0;
		accepted = 1'b0;
		case (cmd)
			CMD_START: begin
				ph = PH_STAND;
				rdy = 1'b0;
				rdy_t0 = '0;
				avg_t0 = '0;
				settled = '0;
				touches = '0;
				clear_ring();
				tgt_walk = (c_mode == MODE_WALK);
				ph_t0 = t;
				if (c_settle > 0 && (c_mode == MODE_WALK || c_mode == MODE_INTER))
					ph = PH_SETTLE;
				else
					ph = (c_mode == MODE_WALK) ? PH_WALK : PH_STAND;
			end
			CMD_TOGGLE: begin
				if (c_mode == MODE_INTER && ph != PH_SETTLE && ph != PH_BRAKE &&
						tgt_walk == (ph == PH_WALK)) begin
					tgt_walk = !tgt_walk;
					accepted = 1'b1;
				end
			end
			CMD_TOUCH: begin
				if (ph == PH_BRAKE && rdy && touches != 8'hFF)
					touches = touches + 1'b1;
			end
			default: begin
				if (ph == PH_SETTLE && (t - ph_t0) >= {16'd0, c_settle}) begin
					enter_phase(tgt_walk ? PH_WALK : PH_STAND, t);
					moved = 1'b1;
				end
				if (tgt_walk) begin
					if (ph == PH_STAND || ph == PH_BRAKE) begin
						enter_phase(PH_WALK, t);
						moved = 1'b1;
					end
				end else if (ph == PH_WALK) begin
					enter_phase(PH_BRAKE, t);
					moved = 1'b1;
				end else if (ph == PH_BRAKE) begin
					if (!rdy) begin
						if (fill >= MaxSamples)
							drop_oldest();
						slot = head + fill[RingAw-1:0];
						ring_t[slot] = t;
						ring_vx[slot] = vx;
						ring_vy[slot] = vy;
						ring_wz[slot] = wz;
						sum_vx += vx;
						sum_vy += vy;
						sum_wz += wz;
						fill = fill + 1'b1;
						while (fill > 1 && (t - ring_t[head]) > {16'd0, c_win})
							drop_oldest();
						n = longint'(fill);
						if (c_win > 0 && (t - avg_t0) < {16'd0, c_win})
							calm = 1'b0;
						else
							calm = (longint'(sum_vx) < 0 ? -longint'(sum_vx) : longint'(sum_vx))
									<= longint'(c_speed) * n &&
								(longint'(sum_vy) < 0 ? -longint'(sum_vy) : longint'(sum_vy))
									<= longint'(c_speed) * n &&
								(longint'(sum_wz) < 0 ? -longint'(sum_wz) : longint'(sum_wz))
									<= longint'(c_yaw) * n;
						if (calm) begin
							if (settled != 16'hFFFF)
								settled = settled + 1'b1;
							if (settled >= c_hold) begin
								rdy = 1'b1;
								rdy_t0 = t;
								touches = '0;
							end
						end else begin
							settled = '0;
						end
					end else if (touches >= c_touch || (t - rdy_t0) >= {16'd0, c_tmo}) begin
						enter_phase(PH_STAND, t);
						moved = 1'b1;
					end
				end
			end
		endcase
		walk_mode = (ph == PH_WALK || ph == PH_BRAKE);
		r.st = ph;
		r.md = walk_mode;
		r.jt = moved;
		r.rgc = moved && ph != PH_BRAKE;
		r.rss = moved && ph != PH_BRAKE;
		r.av = walk_mode && ph != PH_BRAKE;
		r.zm = (ph == PH_BRAKE);
		r.sld = walk_mode;
		r.fj = !walk_mode;
		r.ta = accepted;
		return r;
	endfunction

	// receiver stall pattern
	int stall_style = 0;
	int stall_len = 0;
	int stall_phase = 0;
	always @(posedge clk) begin
		if (stall_len == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_len <= $urandom_range(10, 200);
		end else begin
			stall_len <= stall_len - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= (stall_phase % 5) < 2;
		endcase
	end

	task automatic report(string name, logic [1:0] exp_v, logic [1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		status_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending", $time);
			end else begin
				e = expected_status[0];
				expected_status.delete(0);
				report("fsm_state", e.st, fsm_state);
				report("mode", e.md, mode);
				report("just_transitioned", e.jt, just_transitioned);
				report("reset_gait_clock", e.rgc, reset_gait_clock);
				report("reset_swing_state", e.rss, reset_swing_state);
				report("accept_velocity", e.av, accept_velocity);
				report("zero_motion", e.zm, zero_motion);
				report("swing_leg_dynamics", e.sld, swing_leg_dynamics);
				report("foot_jacobians", e.fj, foot_jacobians);
				report("toggle_accepted", e.ta, toggle_accepted);
			end
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WatchdogLimit) begin
			$display("locomotion_mode_supervisor_core regression: fail");
			$finish;
		end
	end

	task automatic send_request(cmd_t cmd, logic [31:0] t, logic signed [15:0] vx,
			logic signed [15:0] vy, logic signed [15:0] wz);
		in_valid <= 1'b1;
		command <= cmd;
		timestamp_ms <= t;
		vel_x <= vx;
		vel_y <= vy;
		yaw_rate <= wz;
		do @(posedge clk); while (in_stall);
		expected_status = {expected_status, supervise(cmd, t, vx, vy, wz)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (expected_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:    c_mode = val[1:0];
			REG_SETTLE:  c_settle = val;
			REG_SPEED:   c_speed = val[14:0];
			REG_YAW:     c_yaw = val[14:0];
			REG_WINDOW:  c_win = val;
			REG_HOLD:    c_hold = val;
			REG_TIMEOUT: c_tmo = val;
			default:     c_touch = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [15:0] m, logic [15:0] st, logic [15:0] sp,
			logic [15:0] yw, logic [15:0] win, logic [15:0] hold, logic [15:0] tmo,
			logic [15:0] tch);
		drain();
		write_reg(REG_MODE, m);
		write_reg(REG_SETTLE, st);
		write_reg(REG_SPEED, sp);
		write_reg(REG_YAW, yw);
		write_reg(REG_WINDOW, win);
		write_reg(REG_HOLD, hold);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_TOUCH, tch);
	endtask

	task automatic test_toggle_rules();
		configure(1, 0, 0, 0, 0, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd5, 0, 0, 0);
		send_request(CMD_START, 32'd10, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd11, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd12, 0, 0, 0);
		configure(3, 10, 0, 0, 0, 0, 0, 0);
		send_request(CMD_START, 32'd20, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd21, 0, 0, 0);
		configure(2, 10, 0, 0, 0, 0, 0, 0);
		send_request(CMD_START, 32'd100, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd101, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd105, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd110, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd111, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd112, 0, 0, 0);
		send_request(CMD_TOUCH, 32'd113, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd114, 0, 0, 0);
	endtask

	task automatic test_braking();
		configure(2, 0, 100, 100, 4, 2, 30, 2);
		send_request(CMD_START, 32'd1000, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd1001, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd1002, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd1003, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd1004, 0, 0, 0);
		send_request(CMD_TOGGLE, 32'd1005, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			send_request(CMD_UPDATE, 32'd1005 + i, 16'sd50, -16'sd40, 16'sd10);
		send_request(CMD_UPDATE, 32'd1010, 16'sd32767, -16'sd32768, 16'sd32767);
		for (int i = 0; i < 6; i++)
			send_request(CMD_UPDATE, 32'd1011 + i, -16'sd20, 16'sd30, -16'sd99);
		repeat (3) send_request(CMD_TOUCH, 32'd1020, 0, 0, 0);
		send_request(CMD_UPDATE, 32'd1021, 0, 0, 0);
	endtask

	task automatic test_extremes();
		configure(16'hFFFC, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h00FF);
		send_request(CMD_START, 32'hFFFF_FFF0, 16'sd32767, 16'sd32767, 16'sd32767);
		send_request(CMD_UPDATE, 32'h0000_FFEF, -16'sd32768, -16'sd32768, -16'sd32768);
		send_request(CMD_UPDATE, 32'hFFFF_FFFF, 16'sd32767, -16'sd1, 16'sd0);
		configure(0, 0, 0, 0, 0, 0, 0, 0);
		send_request(CMD_START, 32'hFFFF_FFFF, 0, 0, 0);
		send_request(CMD_UPDATE, 32'h0000_0000, 16'sd32767, 16'sd32767, -16'sd32768);
		send_request(CMD_UPDATE, 32'h0000_0001, 0, 0, 0);
	endtask

	task automatic test_touchdown_limit();
		configure(2, 0, 16'h7FFF, 16'h7FFF, 0, 0, 16'hFFFF, 16'h00FF);
		send_request(CMD_START, ts, 0, 0, 0);
		send_request(CMD_TOGGLE, ts, 0, 0, 0);
		send_request(CMD_UPDATE, ts, 0, 0, 0);
		send_request(CMD_TOGGLE, ts, 0, 0, 0);
		send_request(CMD_UPDATE, ts, 0, 0, 0);
		send_request(CMD_UPDATE, ts + 1, 0, 0, 0);
		repeat (258) send_request(CMD_TOUCH, ts + 2, 0, 0, 0);
		send_request(CMD_UPDATE, ts + 3, 0, 0, 0);
	endtask

	function automatic logic [15:0] pick(int lo, int hi, logic [15:0] top);
		return ($urandom_range(0, 7) == 0) ? top : 16'($urandom_range(lo, hi));
	endfunction

	function automatic logic signed [15:0] sample(bit wide);
		return wide ? 16'($urandom) : 16'($urandom_range(0, 160) - 80);
	endfunction

	task automatic test_random();
		int k;
		int step_max;
		bit wide;
		cmd_t c;
		for (int round = 0; round < 10; round++) begin
			configure(($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3)) : 16'd2,
				pick(0, 30, 16'hFFFF), pick(0, 120, 16'hFFFF), pick(0, 120, 16'hFFFF),
				pick(0, 200, 16'hFFFF), pick(0, 6, 16'hFFFF), pick(0, 60, 16'hFFFF),
				pick(0, 5, 16'h00FF));
			ts = ($urandom_range(0, 3) == 0) ? $urandom : ts;
			if (round == 5) ts = 32'hFFFF_FFC0;
			step_max = $urandom_range(0, 4);
			wide = ($urandom_range(0, 4) == 0);
			send_request(CMD_START, ts, sample(1), sample(1), sample(1));
			for (int i = 0; i < 70; i++) begin
				k = $urandom_range(0, 99);
				if (k < 62) c = CMD_UPDATE;
				else if (k < 80) c = CMD_TOGGLE;
				else if (k < 97) c = CMD_TOUCH;
				else c = CMD_START;
				if ($urandom_range(0, 60) == 0) ts = $urandom;
				else ts = ts + $urandom_range(0, step_max);
				send_request(c, ts, sample(wide || $urandom_range(0, 30) == 0),
					sample(wide), sample(wide));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_toggle_rules();
		test_braking();
		test_extremes();
		test_touchdown_limit();
		test_random();
		drain();
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && expected_status.size() == 0) begin
			$display("locomotion_mode_supervisor_core regression: pass");
		end else begin
			$display("locomotion_mode_supervisor_core regression: fail");
		end
		$finish;
	end
endmodule
